/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the address walk RTL; empty in
// synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define SWK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be true outside reset
`define SWK_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define SWK_ASSERT(lbl, clk, rst_n, prop, msg)
`define SWK_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* hdl/swk_pkg.sv */
// ----------------------------------------------------------------------------
// swk_pkg
// Shared constants, register codes and record types of the strided subtensor
// address walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swk_pkg;

  // parameter defaults
  localparam int MAX_DIMS_DEF     = 4;
  localparam int INDEX_BITS_DEF   = 16;
  localparam int ADDRESS_BITS_DEF = 48;

  // fixed field geometry
  localparam int FIELD_DIMS     = 4;   // dimensions carried by packed fields
  localparam int FIELD_IX_BITS  = 16;  // one packed size or index
  localparam int STRIDE_BITS    = 32;
  localparam int POS_BITS       = 32;
  localparam int NUM_DIMS_BITS  = 3;
  localparam int FC_BITS        = 3;
  localparam int DC_BITS        = 4;   // holds a dimension count up to 15
  localparam int BASE_BITS      = 48;
  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_INDEX_BITS = 3;

  // input tdata layout
  localparam int IN_FC_LSB      = 0;
  localparam int IN_FIX_LSB     = IN_FC_LSB + FC_BITS;
  localparam int IN_RS_LSB      = IN_FIX_LSB + FIELD_DIMS * FIELD_IX_BITS;
  localparam int IN_RC_LSB      = IN_RS_LSB + FIELD_IX_BITS;
  localparam int IN_FIELD_BITS  = IN_RC_LSB + FIELD_IX_BITS;
  localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;

  // request kinds
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_NEXT  = 1'b1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_NUM_DIMS     = 3'd0,
    REG_DIM_SIZES    = 3'd1,
    REG_STRIDES_LOW  = 3'd2,
    REG_STRIDES_HIGH = 3'd3,
    REG_BASE_ADDRESS = 3'd4
  } swk_reg_t;

  // status of one classified request, front to back
  typedef struct packed {
    logic start;  // opens a walk: back latches the new walk base
    logic err;    // next request with no walk active
    logic last;   // final element of the walk
  } swk_ctl_t;

endpackage

`default_nettype wire

/* hdl/strided_subtensor_address_walk.sv */
// ----------------------------------------------------------------------------
// strided_subtensor_address_walk
// Element address generator for a subtensor of a strided tensor of up to
// four dimensions, walked in row-major order.
// ----------------------------------------------------------------------------
// Usage:
//  - Configure through cfg_wr_en/cfg_index/cfg_wdata while no request is in
//    flight: 0 num_dims, 1 dim_sizes, 2 strides_low, 3 strides_high,
//    4 base_address. Writes to other indexes are dropped.
//  - Input channel in_*: in_tuser = 0 starts a walk (fixed leading indices
//    plus a range on the first free dimension), in_tuser = 1 asks for the
//    next address. Every request gives exactly one result on out_*.
//  - out_tlast marks the final element of a walk; out_tuser flags a next
//    request that arrived with no walk running (address and number zero).
//  - Each result passes the counter step, a 2-entry queue, one stage of
//    index-by-stride products and one stage of summing into the output
//    register.
//  - Throughput is one address per cycle while the queue is not full; the
//    limit is the combinational carry update of the index counter in the front.
//  - Reset (rst_n low, synchronous) clears the walk and the queue and loads
//    num_dims = 1, all other registers zero. No clearing pass.
//  - When out_tready is low the output register holds, the product stage
//    and the queue fill, and in_tready drops once the queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module strided_subtensor_address_walk #(
  parameter int MAX_DIMS     = swk_pkg::MAX_DIMS_DEF,
  parameter int INDEX_BITS   = swk_pkg::INDEX_BITS_DEF,
  parameter int ADDRESS_BITS = swk_pkg::ADDRESS_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration write port
  input  logic                                  cfg_wr_en,
  input  logic [swk_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [swk_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
  // request channel
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // tdata, low bit up: fixed_count[2:0], fixed_indices[66:3],
  // range_start[82:67], range_count[98:83], zero pad to 104
  input  logic [swk_pkg::IN_TDATA_BITS-1:0]     in_tdata,
  input  logic                                  in_tuser,   // mode
  // result channel
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // tdata, low bit up: element_address, element_number, zero pad to bytes
  output logic [((ADDRESS_BITS+swk_pkg::POS_BITS+7)/8)*8-1:0] out_tdata,
  output logic                                  out_tlast,  // last
  output logic                                  out_tuser   // error
);
  import swk_pkg::*;

  localparam int OUT_TDATA_BITS = ((ADDRESS_BITS + POS_BITS + 7) / 8) * 8;
  localparam int IDX_VEC_BITS   = MAX_DIMS * INDEX_BITS;
  localparam int REC_BITS       = $bits(swk_ctl_t) + POS_BITS + IDX_VEC_BITS;

  // configuration registers
  logic [NUM_DIMS_BITS-1:0] num_dims_r;
  logic [CFG_DATA_BITS-1:0] dim_sizes_r, strides_low_r, strides_high_r;
  logic [BASE_BITS-1:0]     base_address_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r      <= NUM_DIMS_BITS'(1);
      dim_sizes_r     <= '0;
      strides_low_r   <= '0;
      strides_high_r  <= '0;
      base_address_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_NUM_DIMS:     num_dims_r     <= cfg_wdata[NUM_DIMS_BITS-1:0];
        REG_DIM_SIZES:    dim_sizes_r    <= cfg_wdata;
        REG_STRIDES_LOW:  strides_low_r  <= cfg_wdata;
        REG_STRIDES_HIGH: strides_high_r <= cfg_wdata;
        REG_BASE_ADDRESS: base_address_r <= cfg_wdata[BASE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // front: classify and step the counter
  logic                    in_accept;
  logic                    q_full;
  swk_ctl_t                f_ctl;
  logic [POS_BITS-1:0]     f_pos;
  logic [IDX_VEC_BITS-1:0] f_idx;

  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;

  swk_front #(
    .MAX_DIMS   (MAX_DIMS),
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept_i        (in_accept),
    .mode_i          (in_tuser),
    .fixed_count_i   (in_tdata[IN_FC_LSB +: FC_BITS]),
    .fixed_indices_i (in_tdata[IN_FIX_LSB +: FIELD_DIMS*FIELD_IX_BITS]),
    .range_start_i   (in_tdata[IN_RS_LSB +: FIELD_IX_BITS]),
    .range_count_i   (in_tdata[IN_RC_LSB +: FIELD_IX_BITS]),
    .num_dims_i      (num_dims_r),
    .dim_sizes_i     (dim_sizes_r),
    .ctl_o           (f_ctl),
    .position_o      (f_pos),
    .idx_o           (f_idx)
  );

  // decoupling queue
  logic                    q_valid, q_pop;
  logic [REC_BITS-1:0]     q_dout;
  swk_ctl_t                q_ctl;
  logic [POS_BITS-1:0]     q_pos;
  logic [IDX_VEC_BITS-1:0] q_idx;

  swk_queue #(
    .WIDTH (REC_BITS)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (in_accept),
    .din_i   ({f_ctl, f_pos, f_idx}),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .dout_o  (q_dout)
  );

  assign {q_ctl, q_pos, q_idx} = q_dout;

  // back: offsets, sum and output register
  logic [ADDRESS_BITS-1:0] b_addr;
  logic [POS_BITS-1:0]     b_number;

  swk_back #(
    .MAX_DIMS     (MAX_DIMS),
    .INDEX_BITS   (INDEX_BITS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid_i        (q_valid),
    .ctl_i          (q_ctl),
    .position_i     (q_pos),
    .idx_i          (q_idx),
    .pop_o          (q_pop),
    .strides_low_i  (strides_low_r),
    .strides_high_i (strides_high_r),
    .base_address_i (base_address_r),
    .valid_o        (out_tvalid),
    .ready_i        (out_tready),
    .address_o      (b_addr),
    .number_o       (b_number),
    .last_o         (out_tlast),
    .err_o          (out_tuser)
  );

  assign out_tdata = OUT_TDATA_BITS'({b_number, b_addr});

endmodule

`default_nettype wire

/* hdl/swk_front.sv */
// ----------------------------------------------------------------------------
// swk_front
// Classifies requests, steps the mixed-radix index counter and emits the
// index vector of each element.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module swk_front #(
  parameter int MAX_DIMS   = swk_pkg::MAX_DIMS_DEF,
  parameter int INDEX_BITS = swk_pkg::INDEX_BITS_DEF
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 accept_i,
  input  logic                                                 mode_i,
  input  logic [swk_pkg::FC_BITS-1:0]                          fixed_count_i,
  input  logic [swk_pkg::FIELD_DIMS*swk_pkg::FIELD_IX_BITS-1:0] fixed_indices_i,
  input  logic [swk_pkg::FIELD_IX_BITS-1:0]                    range_start_i,
  input  logic [swk_pkg::FIELD_IX_BITS-1:0]                    range_count_i,
  input  logic [swk_pkg::NUM_DIMS_BITS-1:0]                    num_dims_i,
  input  logic [swk_pkg::CFG_DATA_BITS-1:0]                    dim_sizes_i,
  output swk_pkg::swk_ctl_t                                    ctl_o,
  output logic [swk_pkg::POS_BITS-1:0]                         position_o,
  output logic [MAX_DIMS*INDEX_BITS-1:0]                       idx_o
);
  import swk_pkg::*;

  localparam int CMP_BITS =
    ((INDEX_BITS > FIELD_IX_BITS) ? INDEX_BITS : FIELD_IX_BITS) + 1;
  localparam logic [CMP_BITS-1:0] EXT_MAX = CMP_BITS'(1) << INDEX_BITS;
  localparam logic [DC_BITS-1:0]  MAX_N   = DC_BITS'(MAX_DIMS);

  // walk state
  logic [INDEX_BITS-1:0]    cnt_r [MAX_DIMS];
  logic [DC_BITS-1:0]       walk_fc_r;
  logic [FIELD_IX_BITS-1:0] walk_range_r;
  logic [POS_BITS-1:0]      pos_r;
  logic                     active_r;

  logic [FIELD_IX_BITS-1:0] size_w [MAX_DIMS];
  logic [INDEX_BITS-1:0]    fix_w  [MAX_DIMS];

  logic [DC_BITS-1:0]       nd_w, n_w, fc_start_w, fc_walk_w, fc_sel_w;
  logic [FIELD_IX_BITS-1:0] range_sel_w;
  logic                     is_start_w;
  logic [MAX_DIMS-1:0]      in_walk_w, fin_old_w, fin_new_w;
  logic [CMP_BITS-1:0]      ext_w  [MAX_DIMS];
  logic [INDEX_BITS-1:0]    step_w [MAX_DIMS];
  logic [INDEX_BITS-1:0]    cnt_nxt [MAX_DIMS];
  logic                     last_w;

  for (genvar gd = 0; gd < MAX_DIMS; gd++) begin : g_dim
    if (gd < FIELD_DIMS) begin : g_field
      assign size_w[gd] = dim_sizes_i[gd*FIELD_IX_BITS +: FIELD_IX_BITS];
      assign fix_w[gd]  = INDEX_BITS'(fixed_indices_i[gd*FIELD_IX_BITS +: FIELD_IX_BITS]);
    end else begin : g_none
      assign size_w[gd] = '0;
      assign fix_w[gd]  = '0;
    end
  end

  // dimension count and fixed count, clamped
  assign nd_w        = DC_BITS'(num_dims_i);
  assign n_w         = (nd_w == '0) ? DC_BITS'(1) : ((nd_w > MAX_N) ? MAX_N : nd_w);
  assign fc_start_w  = (DC_BITS'(fixed_count_i) > n_w) ? n_w : DC_BITS'(fixed_count_i);
  assign fc_walk_w   = (walk_fc_r > n_w) ? n_w : walk_fc_r;
  assign is_start_w  = (mode_i == MODE_START);
  assign fc_sel_w    = is_start_w ? fc_start_w : fc_walk_w;
  assign range_sel_w = is_start_w ? range_count_i : walk_range_r;

  // extents and final digits of the present counter
  always_comb begin
    logic [CMP_BITS-1:0] raw;
    for (int d = 0; d < MAX_DIMS; d++) begin
      in_walk_w[d] = (DC_BITS'(d) >= fc_sel_w) && (DC_BITS'(d) < n_w);
      raw = (DC_BITS'(d) == fc_sel_w) ? CMP_BITS'(range_sel_w) : CMP_BITS'(size_w[d]);
      if (raw == '0) begin
        ext_w[d] = CMP_BITS'(1);
      end else if (raw > EXT_MAX) begin
        ext_w[d] = EXT_MAX;
      end else begin
        ext_w[d] = raw;
      end
      fin_old_w[d] = (CMP_BITS'(cnt_r[d]) + CMP_BITS'(1)) >= ext_w[d];
    end
  end

  // ripple carry from the last dimension down to the first free one
  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int d = MAX_DIMS - 1; d >= 0; d--) begin
      step_w[d] = cnt_r[d];
      if (in_walk_w[d] && carry) begin
        if (!fin_old_w[d]) begin
          step_w[d] = cnt_r[d] + INDEX_BITS'(1);
          carry     = 1'b0;
        end else begin
          step_w[d] = '0;
        end
      end
    end
  end

  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (is_start_w) begin
        cnt_nxt[d] = '0;
      end else if (active_r) begin
        cnt_nxt[d] = step_w[d];
      end else begin
        cnt_nxt[d] = cnt_r[d];
      end
      fin_new_w[d] = !in_walk_w[d] ||
                     ((CMP_BITS'(cnt_nxt[d]) + CMP_BITS'(1)) >= ext_w[d]);
    end
  end

  assign last_w = &fin_new_w;

  // outgoing record
  always_comb begin
    ctl_o.start = is_start_w;
    ctl_o.err   = !is_start_w && !active_r;
    ctl_o.last  = (is_start_w || active_r) && last_w;
    position_o  = is_start_w ? '0 : (active_r ? pos_r + POS_BITS'(1) : '0);
    for (int d = 0; d < MAX_DIMS; d++) begin
      idx_o[d*INDEX_BITS +: INDEX_BITS] = '0;
      if (is_start_w) begin
        if (DC_BITS'(d) < fc_start_w) begin
          idx_o[d*INDEX_BITS +: INDEX_BITS] = fix_w[d];
        end else if ((DC_BITS'(d) == fc_start_w) && (fc_start_w < n_w)) begin
          idx_o[d*INDEX_BITS +: INDEX_BITS] = INDEX_BITS'(range_start_i);
        end
      end else if (active_r && in_walk_w[d]) begin
        idx_o[d*INDEX_BITS +: INDEX_BITS] = cnt_nxt[d];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      pos_r        <= '0;
      walk_fc_r    <= '0;
      walk_range_r <= '0;
      cnt_r        <= '{default: '0};
    end else if (accept_i) begin
      if (is_start_w) begin
        walk_fc_r    <= fc_start_w;
        walk_range_r <= range_count_i;
        pos_r        <= '0;
        active_r     <= !last_w;
        cnt_r        <= cnt_nxt;
      end else if (active_r) begin
        pos_r    <= pos_r + POS_BITS'(1);
        active_r <= !last_w;
        cnt_r    <= cnt_nxt;
      end
    end
  end

  `SWK_ASSERT(fr_last_ends_walk, clk, rst_n, (accept_i && ctl_o.last) |=> !active_r, "walk still active after its last element")
  `SWK_ASSERT(fr_pos_advance, clk, rst_n, (accept_i && !is_start_w && active_r) |=> (pos_r == $past(pos_r) + POS_BITS'(1)), "element number did not advance by one")

endmodule

`default_nettype wire

/* hdl/swk_queue.sv */
// ----------------------------------------------------------------------------
// swk_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module swk_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  logic [WIDTH-1:0] din_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] dout_o
);

  logic [WIDTH-1:0] head_r, tail_r;
  logic [1:0]       count_r, count_nxt;
  logic             do_push, do_pop;

  assign full_o  = (count_r == 2'd2);
  assign valid_o = (count_r != 2'd0);
  assign dout_o  = head_r;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      if (count_r == 2'd2) begin
        head_r <= tail_r;
        if (do_push) begin
          tail_r <= din_i;
        end
      end else if (do_push) begin
        head_r <= din_i;
      end
    end else if (do_push) begin
      if (count_r == 2'd0) begin
        head_r <= din_i;
      end else begin
        tail_r <= din_i;
      end
    end
  end

  `SWK_NEVER(q_push_full, clk, rst_n, push_i && full_o, "request pushed into a full queue")

endmodule

`default_nettype wire

/* hdl/swk_back.sv */
// ----------------------------------------------------------------------------
// swk_back
// Multiplies indices by strides, sums the offsets onto the walk base and
// holds the result for the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module swk_back #(
  parameter int MAX_DIMS     = swk_pkg::MAX_DIMS_DEF,
  parameter int INDEX_BITS   = swk_pkg::INDEX_BITS_DEF,
  parameter int ADDRESS_BITS = swk_pkg::ADDRESS_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                valid_i,
  input  swk_pkg::swk_ctl_t                   ctl_i,
  input  logic [swk_pkg::POS_BITS-1:0]        position_i,
  input  logic [MAX_DIMS*INDEX_BITS-1:0]      idx_i,
  output logic                                pop_o,
  input  logic [swk_pkg::CFG_DATA_BITS-1:0]   strides_low_i,
  input  logic [swk_pkg::CFG_DATA_BITS-1:0]   strides_high_i,
  input  logic [swk_pkg::BASE_BITS-1:0]       base_address_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic [ADDRESS_BITS-1:0]             address_o,
  output logic [swk_pkg::POS_BITS-1:0]        number_o,
  output logic                                last_o,
  output logic                                err_o
);
  import swk_pkg::*;

  localparam int PROD_BITS = INDEX_BITS + STRIDE_BITS;

  logic [STRIDE_BITS-1:0]  stride_w [MAX_DIMS];

  // product stage
  logic                    p_valid_r;
  swk_ctl_t                p_ctl_r;
  logic [POS_BITS-1:0]     p_pos_r;
  logic [PROD_BITS-1:0]    p_prod_r [MAX_DIMS];

  // output stage
  logic                    o_valid_r;
  logic [ADDRESS_BITS-1:0] o_addr_r;
  logic [POS_BITS-1:0]     o_pos_r;
  logic                    o_last_r, o_err_r;
  logic [ADDRESS_BITS-1:0] walk_base_r;

  logic                    o_ready, p_ready;
  logic [ADDRESS_BITS-1:0] sum_w;

  for (genvar gd = 0; gd < MAX_DIMS; gd++) begin : g_stride
    if (gd < 2) begin : g_low
      assign stride_w[gd] = strides_low_i[gd*STRIDE_BITS +: STRIDE_BITS];
    end else if (gd < FIELD_DIMS) begin : g_high
      assign stride_w[gd] = strides_high_i[(gd-2)*STRIDE_BITS +: STRIDE_BITS];
    end else begin : g_none
      assign stride_w[gd] = '0;
    end
  end

  assign o_ready = !o_valid_r || ready_i;
  assign p_ready = !p_valid_r || o_ready;
  assign pop_o   = valid_i && p_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (p_ready) begin
      p_valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_o) begin
      p_ctl_r <= ctl_i;
      p_pos_r <= position_i;
      for (int d = 0; d < MAX_DIMS; d++) begin
        p_prod_r[d] <= PROD_BITS'(idx_i[d*INDEX_BITS +: INDEX_BITS]) *
                       PROD_BITS'(stride_w[d]);
      end
    end
  end

  // address: modular sum of offsets onto the base
  always_comb begin
    sum_w = p_ctl_r.start ? ADDRESS_BITS'(base_address_i) : walk_base_r;
    for (int d = 0; d < MAX_DIMS; d++) begin
      sum_w = sum_w + ADDRESS_BITS'(p_prod_r[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (o_ready) begin
      o_valid_r <= p_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid_r && o_ready) begin
      o_addr_r <= p_ctl_r.err ? '0 : sum_w;
      o_pos_r  <= p_pos_r;
      o_last_r <= p_ctl_r.last;
      o_err_r  <= p_ctl_r.err;
    end
  end

  // walk base, latched as a start request leaves the product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_base_r <= '0;
    end else if (p_valid_r && o_ready && p_ctl_r.start) begin
      walk_base_r <= sum_w;
    end
  end

  assign valid_o   = o_valid_r;
  assign address_o = o_addr_r;
  assign number_o  = o_pos_r;
  assign last_o    = o_last_r;
  assign err_o     = o_err_r;

  `SWK_ASSERT(bk_base_hold, clk, rst_n, (p_valid_r && o_ready && !p_ctl_r.start) |=> $stable(walk_base_r), "walk base changed outside a start request")

endmodule

`default_nettype wire

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb: strided subtensor address walk testbench
// Drives start and next requests into the address walker and checks every
// result (address, element number, last, error) against an in-bench model of
// the walk, under random source gaps, sink stalls and one long sink hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import swk_pkg::*;

  localparam int OUT_BITS = ((ADDRESS_BITS_DEF + POS_BITS + 7) / 8) * 8;
  localparam int ITEM_TARGET = 1050;
  localparam int HOLD_CYCLES = 300;

  // one request as the bench sees it
  typedef struct packed {
    logic        mode;
    logic [2:0]  fixed_count;
    logic [63:0] fixed_indices;
    logic [15:0] range_start;
    logic [15:0] range_count;
  } walk_req_t;

  // one result
  typedef struct packed {
    logic [47:0] addr;
    logic [31:0] number;
    logic        last;
    logic        err;
  } walk_res_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_wr_en;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_TDATA_BITS-1:0] in_tdata;
  logic                     in_tuser;
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_BITS-1:0]      out_tdata;
  logic                     out_tlast;
  logic                     out_tuser;

  strided_subtensor_address_walk dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // requests waiting for the driver, and results the walker still owes us
  walk_req_t pending_reqs[$];
  walk_res_t expected_elems[$];

  int  mismatch_count = 0;
  int  items_queued   = 0;
  bit  req_fire       = 0;   // request handshake seen at the last rising edge
  bit  send_idle      = 0;   // source inserts random gaps
  bit  recv_idle      = 0;   // sink inserts random stalls
  bit  hold_go        = 0;   // ask the sink for one long hold-off
  int  hold_left      = 0;

  // shadow copy of the configuration registers
  logic [2:0]  r_num_dims;
  logic [63:0] r_sizes;
  logic [63:0] r_str_lo;
  logic [63:0] r_str_hi;
  logic [47:0] r_base;

  // shadow copy of the walk state
  logic [15:0] ix_cnt[MAX_DIMS_DEF];
  logic [47:0] pw_base;
  logic [2:0]  pw_fc;
  logic [15:0] pw_rc;
  logic [31:0] pw_pos;
  logic        pw_active;

  // --------------------------------------------------------------------------
  // Walk model
  // --------------------------------------------------------------------------

  // num_dims of 0 reads as 1, anything above four as four
  function automatic int dims_used();
    int n;
    n = int'(r_num_dims);
    if (n < 1) n = 1;
    if (n > MAX_DIMS_DEF) n = MAX_DIMS_DEF;
    return n;
  endfunction

  function automatic logic [15:0] size_of(int d);
    return r_sizes[FIELD_IX_BITS*d +: FIELD_IX_BITS];
  endfunction

  function automatic logic [31:0] stride_of(int d);
    if (d < 2) return r_str_lo[STRIDE_BITS*d +: STRIDE_BITS];
    return r_str_hi[STRIDE_BITS*(d-2) +: STRIDE_BITS];
  endfunction

  // stored fixed count, clamped against the dimensions in use right now
  function automatic int free_from();
    int n;
    n = dims_used();
    return (int'(pw_fc) > n) ? n : int'(pw_fc);
  endfunction

  // range dimension uses range_count, others their size; zero counts as one
  function automatic int extent_of(int d, int fc);
    int e;
    e = (d == fc) ? int'(pw_rc) : int'(size_of(d));
    if (e == 0) e = 1;
    return e;
  endfunction

  function automatic walk_res_t emit_element();
    walk_res_t   res;
    logic [63:0] a;
    int          n, fc, d;
    logic        fin;
    n   = dims_used();
    fc  = free_from();
    a   = pw_base;
    fin = 1'b1;
    for (d = fc; d < n; d++) begin
      if (int'(ix_cnt[d]) + 1 < extent_of(d, fc)) fin = 1'b0;
      a += ix_cnt[d] * stride_of(d);
    end
    res.addr   = a[47:0];
    res.number = pw_pos;
    res.last   = fin;
    res.err    = 1'b0;
    pw_active  = !fin;
    return res;
  endfunction

  // advance the model by one accepted request, return the element it yields
  function automatic walk_res_t step_walk(walk_req_t q);
    walk_res_t   res;
    logic [63:0] b;
    int          n, fc, d, k;
    bit          carried;
    n = dims_used();
    if (q.mode == MODE_START) begin
      fc = int'(q.fixed_count);
      if (fc > n) fc = n;
      b = r_base;
      for (d = 0; d < fc; d++)
        b += q.fixed_indices[FIELD_IX_BITS*d +: FIELD_IX_BITS] * stride_of(d);
      if (fc < n) b += q.range_start * stride_of(fc);
      for (d = 0; d < MAX_DIMS_DEF; d++) ix_cnt[d] = '0;
      pw_base = b[47:0];
      pw_fc   = 3'(fc);
      pw_rc   = q.range_count;
      pw_pos  = '0;
      return emit_element();
    end
    if (!pw_active) begin
      res     = '0;
      res.err = 1'b1;
      return res;
    end
    // mixed-radix counter, last dimension fastest; a counter at or past its
    // extent (after a register change) wraps on the carry
    fc      = free_from();
    carried = 0;
    for (k = n - 1; k >= fc && !carried; k--) begin
      if (int'(ix_cnt[k]) + 1 < extent_of(k, fc)) begin
        ix_cnt[k] = ix_cnt[k] + 16'd1;
        carried   = 1;
      end else begin
        ix_cnt[k] = '0;
      end
    end
    pw_pos = pw_pos + 32'd1;
    return emit_element();
  endfunction

  // --------------------------------------------------------------------------
  // Clock and timeout
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Request driver: a request stays valid until taken, gaps only in between
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : req_driver
    walk_req_t               q;
    logic [IN_TDATA_BITS-1:0] word;
    if (!in_tvalid || req_fire) begin
      if (pending_reqs.size() != 0 && !(send_idle && $urandom_range(99) < 35)) begin
        q    = pending_reqs.pop_front();
        word = '0;
        word[IN_FC_LSB  +: FC_BITS]                    = q.fixed_count;
        word[IN_FIX_LSB +: FIELD_DIMS * FIELD_IX_BITS] = q.fixed_indices;
        word[IN_RS_LSB  +: FIELD_IX_BITS]              = q.range_start;
        word[IN_RC_LSB  +: FIELD_IX_BITS]              = q.range_count;
        in_tvalid <= 1'b1;
        in_tdata  <= word;
        in_tuser  <= q.mode;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: random stalls, plus one long hold-off on request so the
  // internal queue fills and in_tready drops
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : res_sink
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_go) begin
      hold_go    = 0;
      hold_left  = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(recv_idle && $urandom_range(99) < 35);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check results, then predict for the request taken at this edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    walk_res_t want;
    walk_req_t q;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_elems.size() == 0) begin
          $error("result with no element expected: address %h", out_tdata[47:0]);
          mismatch_count++;
        end else begin
          want = expected_elems.pop_front();
          if (out_tdata[47:0] !== want.addr) begin
            $error("element_address: expected %h, got %h", want.addr, out_tdata[47:0]);
            mismatch_count++;
          end
          if (out_tdata[79:48] !== want.number) begin
            $error("element_number: expected %0d, got %0d", want.number,
                   out_tdata[79:48]);
            mismatch_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_tlast);
            mismatch_count++;
          end
          if (out_tuser !== want.err) begin
            $error("error: expected %b, got %b", want.err, out_tuser);
            mismatch_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        q.mode          = in_tuser;
        q.fixed_count   = in_tdata[IN_FC_LSB  +: FC_BITS];
        q.fixed_indices = in_tdata[IN_FIX_LSB +: FIELD_DIMS * FIELD_IX_BITS];
        q.range_start   = in_tdata[IN_RS_LSB  +: FIELD_IX_BITS];
        q.range_count   = in_tdata[IN_RC_LSB  +: FIELD_IX_BITS];
        expected_elems.push_back(step_walk(q));
      end
      req_fire = in_tvalid && in_tready;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic walk_req_t mk_req(logic m, logic [2:0] fc, logic [63:0] fix,
                                       logic [15:0] rs, logic [15:0] rc);
    walk_req_t q;
    q.mode          = m;
    q.fixed_count   = fc;
    q.fixed_indices = fix;
    q.range_start   = rs;
    q.range_count   = rc;
    return q;
  endfunction

  task automatic push_req(walk_req_t q);
    pending_reqs.push_back(q);
    items_queued++;
  endtask

  // wait until every request is taken and answered, then let the pipe settle
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_tvalid || expected_elems.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // write all five registers, one per cycle, and mirror them in the model
  task automatic set_config(logic [63:0] nd, logic [63:0] sizes, logic [63:0] slo,
                            logic [63:0] shi, logic [63:0] base);
    swk_reg_t    regs[5];
    logic [63:0] vals[5];
    int          i;
    regs = '{REG_NUM_DIMS, REG_DIM_SIZES, REG_STRIDES_LOW, REG_STRIDES_HIGH,
             REG_BASE_ADDRESS};
    vals = '{nd, sizes, slo, shi, base};
    for (i = 0; i < 5; i++) begin
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
      case (regs[i])
        REG_NUM_DIMS:     r_num_dims = vals[i][2:0];
        REG_DIM_SIZES:    r_sizes    = vals[i];
        REG_STRIDES_LOW:  r_str_lo   = vals[i];
        REG_STRIDES_HIGH: r_str_hi   = vals[i];
        REG_BASE_ADDRESS: r_base     = vals[i][47:0];
        default: ;
      endcase
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly complete walks with random content, some cut short or overrun,
  // and a few lone next requests as noise
  task automatic fill_phase(int count);
    int          made, n, fc, fce, d, e, nx, t, i;
    longint      len;
    logic [15:0] rc, rs;
    logic [63:0] fix;
    made = 0;
    while (made < count) begin
      if ($urandom_range(99) < 85) begin
        n   = dims_used();
        fc  = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(n);
        fce = (fc > n) ? n : fc;
        if ($urandom_range(3) == 0)
          fix = rand64();
        else
          fix = {16'($urandom_range(5)), 16'($urandom_range(5)),
                 16'($urandom_range(5)), 16'($urandom_range(5))};
        rs = ($urandom_range(1) == 0) ? 16'($urandom_range(7)) : 16'($urandom);
        t  = $urandom_range(9);
        if (t < 4)       rc = 16'($urandom_range(1, 4));
        else if (t == 4) rc = '0;
        else if (t == 5) rc = 16'($urandom);
        else             rc = 16'($urandom_range(1, 8));
        // elements in this walk, capped
        len = 1;
        for (d = fce; d < n; d++) begin
          e = (d == fce) ? int'(rc) : int'(size_of(d));
          if (e == 0) e = 1;
          len = len * e;
          if (len > 1000) len = 1000;
        end
        nx = (len <= 40) ? int'(len) - 1 : $urandom_range(20);
        t  = $urandom_range(9);
        if (t == 0)               nx = nx + 1 + $urandom_range(1);  // runs past the end
        else if (t == 1 && nx > 0) nx = $urandom_range(nx - 1);     // dropped by a restart
        push_req(mk_req(MODE_START, 3'(fc), fix, rs, rc));
        for (i = 0; i < nx; i++)
          push_req(mk_req(MODE_NEXT, 3'($urandom), rand64(), 16'($urandom), 16'($urandom)));
        made += 1 + nx;
      end else begin
        push_req(mk_req(MODE_NEXT, 3'($urandom), rand64(), 16'($urandom), 16'($urandom)));
        made++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    int          ph, d;
    logic [63:0] sizes;
    rst_n      = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_index  = REG_NUM_DIMS;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = MODE_START;
    out_tready = 1'b0;
    // model at its reset values
    r_num_dims = 3'd1;
    r_sizes    = '0;
    r_str_lo   = '0;
    r_str_hi   = '0;
    r_base     = '0;
    for (d = 0; d < MAX_DIMS_DEF; d++) ix_cnt[d] = '0;
    pw_base   = '0;
    pw_fc     = '0;
    pw_rc     = '0;
    pw_pos    = '0;
    pw_active = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part, reset configuration first
    @(posedge clk);
    push_req(mk_req(MODE_NEXT,  3'd0, '0, '0, '0));    // next while idle
    push_req(mk_req(MODE_START, 3'd0, '0, '0, '0));    // zero range reads as one
    push_req(mk_req(MODE_NEXT,  3'd0, '0, '0, '0));    // walk already done
    wait_idle();

    // three dims 4x3x2, one huge stride, base near the top so addresses wrap;
    // junk in the upper bits of the base write
    set_config(64'd3, {16'd0, 16'd2, 16'd3, 16'd4},
               {32'hFFFF_FFFF, 32'd1000}, {32'd5, 32'd7},
               64'hABCD_FFFF_FFFF_F000);
    @(posedge clk);
    push_req(mk_req(MODE_START, 3'd1, 64'd2, 16'd1, 16'd2));   // 2x2 block
    repeat (3) push_req(mk_req(MODE_NEXT, 3'd0, '0, '0, '0));
    push_req(mk_req(MODE_NEXT,  3'd0, '0, '0, '0));            // past the end
    push_req(mk_req(MODE_START, 3'd3, {16'd0, 16'd1, 16'd2, 16'd3}, '0, 16'd5)); // all fixed
    push_req(mk_req(MODE_START, 3'd7, '1, '1, '1));            // fixed count clamped
    push_req(mk_req(MODE_START, 3'd0, '1, '1, '1));            // widest range
    repeat (2) push_req(mk_req(MODE_NEXT, 3'd7, '1, '1, '1));
    push_req(mk_req(MODE_START, 3'd2, '1, '1, 16'd1));         // restart while active
    push_req(mk_req(MODE_NEXT,  3'd0, '0, '0, '0));
    push_req(mk_req(MODE_START, 3'd1, '0, '0, '0));            // zero count on range dim
    push_req(mk_req(MODE_NEXT,  3'd0, '0, '0, '0));
    // long walk left running across the next register change
    push_req(mk_req(MODE_START, 3'd0, '0, 16'd3, 16'd200));
    repeat (2) push_req(mk_req(MODE_NEXT, 3'd0, '0, '0, '0));
    wait_idle();

    // random phases, each under its own configuration
    ph = 0;
    while (items_queued < ITEM_TARGET) begin
      if (ph == 0) begin
        set_config('1, '1, '1, '1, '1);          // everything at its top
      end else if (ph == 1) begin
        set_config('0, '0, '0, '0, '0);          // everything zero
      end else begin
        for (d = 0; d < MAX_DIMS_DEF; d++)
          sizes[FIELD_IX_BITS*d +: FIELD_IX_BITS] =
            ($urandom_range(5) == 0) ? 16'($urandom) : 16'($urandom_range(4));
        set_config(($urandom_range(4) == 0) ? rand64() : 64'($urandom_range(1, 4)),
                   sizes, rand64(), rand64(), rand64());
      end
      @(posedge clk);
      // phase 2 runs flat out; phase 3 carries the long sink hold-off
      send_idle = (ph != 2);
      recv_idle = (ph != 2);
      hold_go   = (ph == 3);
      fill_phase((ph < 2) ? 60 : 110);
      wait_idle();
      ph++;
    end

    if (mismatch_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/swk_pkg.sv
hdl/swk_front.sv
hdl/swk_queue.sv
hdl/swk_back.sv
hdl/strided_subtensor_address_walk.sv
sim/tb.sv
